FILE: src/cpfa_pkg.sv
// Shared types and constants for the core partition fit allocator.
// No dependencies; every other file imports this package.
package cpfa_pkg;

  localparam int CORES          = 4;
  localparam int UTIL_FRAC_BITS = 16;

  // A task field holds up to (but excluding) 2.0; a load never exceeds 1.0.
  localparam int UTIL_W = UTIL_FRAC_BITS + 1;
  // Load plus task needs one more bit.
  localparam int SUM_W  = UTIL_W + 1;
  // Core counter width, at least one bit so a single core still works.
  localparam int CIDX_W = (CORES > 1) ? $clog2(CORES) : 1;
  // Room to widen the counter to the two-bit result field.
  localparam int IDX_EXT_W = (CIDX_W > 2) ? CIDX_W : 2;

  localparam logic [SUM_W-1:0] UNIT_LOAD = SUM_W'(1) << UTIL_FRAC_BITS;
  localparam logic [CIDX_W-1:0] LAST_CORE = CIDX_W'(CORES - 1);

  typedef enum logic [1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2
  } fit_mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } ctl_state_e;

  typedef struct packed {
    logic [UTIL_W-1:0] task_utilization;
    logic              first_of_set;
  } cpfa_in_t;

  typedef struct packed {
    logic [1:0] core_index;
    logic       placed;
  } cpfa_out_t;

  // Controller to datapath.
  typedef struct packed {
    logic start;   // latch a request, clear loads if flagged
    logic step;    // evaluate the core under the scan counter
    logic commit;  // write back the load and fill the output register
  } cpfa_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic last_core;
  } cpfa_sts_t;

endpackage

FILE: src/cpfa_datapath.sv
// Datapath: core load registers, one shared adder/comparator scan, result register.
// Depends on cpfa_pkg.
module cpfa_datapath import cpfa_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cpfa_cmd_t     cmd_i,
  output cpfa_sts_t     sts_o,
  input  logic [1:0]    fit_mode_i,
  input  cpfa_in_t      in_data_i,
  output cpfa_out_t     out_data_o
);

  logic [UTIL_W-1:0] load_q [CORES];
  logic [UTIL_W-1:0] load_d [CORES];
  logic [UTIL_W-1:0] task_q;
  logic [CIDX_W-1:0] cnt_q, cnt_d;
  logic [CIDX_W-1:0] chosen_q, chosen_d;
  logic [SUM_W-1:0]  best_q, best_d;
  logic              found_q, found_d;
  cpfa_out_t         out_q, out_d;
  logic [SUM_W-1:0]  total;
  logic              qualify;
  // A placed load never exceeds 1.0, so the write-back sum fits a load register.
  logic [UTIL_W-1:0] new_load;
  logic [IDX_EXT_W-1:0] chosen_ext;

  assign total    = {1'b0, load_q[cnt_q]} + {1'b0, task_q};
  assign new_load = load_q[chosen_q] + task_q;
  assign chosen_ext = IDX_EXT_W'(chosen_q);

  always_comb begin
    unique case (fit_mode_e'(fit_mode_i))
      FIT_BEST:  qualify = (total <= UNIT_LOAD) && (total > best_q);
      FIT_WORST: qualify = (total < UNIT_LOAD) && (total < best_q);
      default:   qualify = !found_q && (total <= UNIT_LOAD);
    endcase
  end

  always_comb begin
    cnt_d    = cnt_q;
    chosen_d = chosen_q;
    best_d   = best_q;
    found_d  = found_q;
    out_d    = out_q;
    for (int c = 0; c < CORES; c++) begin
      load_d[c] = load_q[c];
    end

    if (cmd_i.step) begin
      cnt_d = cnt_q + CIDX_W'(1);
      if (qualify) begin
        best_d   = total;
        chosen_d = cnt_q;
        found_d  = 1'b1;
      end
    end

    if (cmd_i.commit) begin
      if (found_q) begin
        load_d[chosen_q] = new_load;
      end
      out_d.core_index = found_q ? chosen_ext[1:0] : 2'd0;
      out_d.placed     = found_q;
    end

    // A new request may arrive in the commit cycle; its clear follows the write.
    if (cmd_i.start) begin
      cnt_d    = '0;
      chosen_d = '0;
      found_d  = 1'b0;
      best_d   = (fit_mode_e'(fit_mode_i) == FIT_WORST) ? UNIT_LOAD : '0;
      if (in_data_i.first_of_set) begin
        for (int c = 0; c < CORES; c++) begin
          load_d[c] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CORES; c++) begin
        load_q[c] <= '0;
      end
    end else begin
      for (int c = 0; c < CORES; c++) begin
        load_q[c] <= load_d[c];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      task_q <= in_data_i.task_utilization;
    end
    cnt_q    <= cnt_d;
    chosen_q <= chosen_d;
    best_q   <= best_d;
    found_q  <= found_d;
    out_q    <= out_d;
  end

  assign sts_o.last_core = (cnt_q == LAST_CORE);
  assign out_data_o      = out_q;

endmodule

FILE: src/cpfa_ctrl.sv
// Controller: sequences accept, core scan and write-back; owns the output valid.
// Depends on cpfa_pkg.
module cpfa_ctrl import cpfa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output cpfa_cmd_t cmd_o,
  input  cpfa_sts_t sts_i
);

  ctl_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  logic       accept;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    in_stall_o = !((state_q == ST_IDLE) || ((state_q == ST_WRITE) && out_free));
  end

  assign accept = in_valid_i && !in_stall_o;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts_i.last_core) state_d = ST_WRITE;
      end
      ST_WRITE: begin
        if (out_free) state_d = accept ? ST_SCAN : ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o.start  = accept;
    cmd_o.step   = (state_q == ST_SCAN);
    cmd_o.commit = (state_q == ST_WRITE) && out_free;

    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: src/core_partition_fit_allocator.sv
// Top level of the core partition fit allocator: mode register, controller, datapath.
// Depends on cpfa_pkg, cpfa_ctrl and cpfa_datapath.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+----------------------------------------
//   in       | in_valid_i / in_stall_o | in_data_i  (task_utilization, first_of_set)
//   out      | out_valid_o / out_stall_i | out_data_o (core_index, placed)
//   config   | cfg_we_i                | cfg_wdata_i (fit_mode)
//
// Each request is scanned one core per cycle through the single shared
// adder/comparator, then written back in the write-back state, in which
// the next request can already be accepted.
// Reset clears all core loads, the mode (first-fit) and the output valid.
// A result waits in the output register while out_stall_i is high; the block
// still takes and scans one new request, holding it at write-back until the
// output register frees up.
module core_partition_fit_allocator import cpfa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  cpfa_in_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output cpfa_out_t  out_data_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i
);

  logic [1:0] fit_mode_q;
  cpfa_cmd_t  cmd;
  cpfa_sts_t  sts;

  // Placement policy register; code three falls back to first-fit downstream.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_mode_q <= FIT_FIRST;
    end else if (cfg_we_i) begin
      fit_mode_q <= cfg_wdata_i;
    end
  end

  cpfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  cpfa_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .fit_mode_i (fit_mode_q),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

endmodule

FILE: test/cpfa_fit_scoreboard.sv
// Scoreboard for the core partition fit allocator testbench: per-core load
// prediction under the selected fit policy plus an in-order result check.
// Depends on cpfa_pkg.
package cpfa_tb_pkg;
  import cpfa_pkg::*;

  class fit_scoreboard;
    logic [1:0]        mode;
    logic [UTIL_W-1:0] load [CORES];
    cpfa_out_t         placement_q [$];
    int                errors;
    int                requests;
    int                placed_seen;
    int                rejected_seen;

    function new();
      mode          = FIT_FIRST;
      errors        = 0;
      requests      = 0;
      placed_seen   = 0;
      rejected_seen = 0;
      foreach (load[c]) load[c] = '0;
    endfunction

    function void set_mode(logic [1:0] m);
      mode = m;
    endfunction

    function int pending();
      return placement_q.size();
    endfunction

    // Place one accepted request on the predicted cores and queue its result.
    function void note_request(cpfa_in_t req);
      logic [SUM_W-1:0] total;
      logic [SUM_W-1:0] best;
      int               chosen;
      bit               found;
      cpfa_out_t        placement;

      requests++;
      if (req.first_of_set) begin
        foreach (load[c]) load[c] = '0;
      end
      best   = (mode == FIT_WORST) ? UNIT_LOAD : '0;
      chosen = 0;
      found  = 1'b0;
      for (int c = 0; c < CORES; c++) begin
        total = SUM_W'(load[c]) + SUM_W'(req.task_utilization);
        case (mode)
          FIT_BEST: begin
            if (total <= UNIT_LOAD && total > best) begin
              best   = total;
              chosen = c;
              found  = 1'b1;
            end
          end
          FIT_WORST: begin
            if (total < UNIT_LOAD && total < best) begin
              best   = total;
              chosen = c;
              found  = 1'b1;
            end
          end
          default: begin
            if (!found && total <= UNIT_LOAD) begin
              chosen = c;
              found  = 1'b1;
            end
          end
        endcase
      end
      if (found) begin
        load[chosen]          = load[chosen] + req.task_utilization;
        placement.core_index  = 2'(chosen);
        placement.placed      = 1'b1;
      end else begin
        placement = '0;
      end
      placement_q.push_back(placement);
    endfunction

    // Compare one accepted result with the oldest queued placement.
    function void check_result(cpfa_out_t got);
      cpfa_out_t exp_res;

      if (placement_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result core %0d placed %0d", $time,
                 got.core_index, got.placed);
        return;
      end
      exp_res = placement_q.pop_front();
      if (got.placed) placed_seen++;
      else rejected_seen++;
      if (got.core_index !== exp_res.core_index) begin
        errors++;
        $display("%0t: core_index mismatch, expected %0d actual %0d", $time,
                 exp_res.core_index, got.core_index);
      end
      if (got.placed !== exp_res.placed) begin
        errors++;
        $display("%0t: placed mismatch, expected %0d actual %0d", $time,
                 exp_res.placed, got.placed);
      end
    endfunction
  endclass

endpackage

FILE: test/tb_core_partition_fit_allocator.sv
// Self-checking testbench for core_partition_fit_allocator: directed and random
// task streams under every fit mode, with random idling on both channels.
// Depends on cpfa_pkg and cpfa_tb_pkg (scoreboard class).
module tb_core_partition_fit_allocator;
  import cpfa_pkg::*;
  import cpfa_tb_pkg::*;

  // Mode value outside the enum; the block treats it as first-fit.
  localparam logic [1:0] FIT_MODE_THREE = 2'd3;
  localparam int PHASES          = 12;
  localparam int PHASE_REQUESTS  = 150;
  localparam int LONG_HOLD       = 80;
  localparam int WATCHDOG_LIMIT  = 3000;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  cpfa_in_t   in_data_i   = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  cpfa_out_t  out_data_o;
  logic       cfg_we_i    = 1'b0;
  logic [1:0] cfg_wdata_i = '0;

  fit_scoreboard sb;

  // Idling on both channels is on unless a phase runs at full rate.
  bit idle_enable   = 1'b0;
  // Raised by the stimulus to make the receiver start its long hold-off (LONG_HOLD).
  bit long_hold_req = 1'b0;
  int idle_cycles   = 0;

  core_partition_fit_allocator u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 0;
  end

  // Gap before a request: mostly none, some short, a few long.
  function automatic int gap_len();
    int pick;

    if (!idle_enable) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 65) return 0;
    if (pick < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Pick a utilization that lands near the interesting boundaries: exact fits
  // against the current load of some core, full and empty tasks, oversized ones.
  function automatic logic [UTIL_W-1:0] pick_utilization();
    int                pick;
    int                k;
    logic [UTIL_W-1:0] room;

    k    = $urandom_range(0, CORES - 1);
    room = UTIL_W'(UNIT_LOAD - SUM_W'(sb.load[k]));
    pick = $urandom_range(0, 99);
    if (pick < 8)  return '0;
    if (pick < 14) return UTIL_W'(UNIT_LOAD);
    if (pick < 20) return UTIL_W'($urandom_range(65537, 131071));
    if (pick < 40) return room;
    if (pick < 45) return room + 1'b1;
    if (pick < 50) return (room == '0) ? room : room - 1'b1;
    if (pick < 75) return UTIL_W'($urandom_range(0, 16383));
    return UTIL_W'($urandom_range(0, 65536));
  endfunction

  // Offer one request, hold it until accepted, then predict its placement.
  task automatic send_request(logic [UTIL_W-1:0] util, logic first);
    int       gap;
    cpfa_in_t req;

    gap                  = gap_len();
    req.task_utilization = util;
    req.first_of_set     = first;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i);
    while (in_stall_o);
    sb.note_request(req);
  endtask

  // Drop valid and wait until every queued result is out, then let the
  // block sit idle before returning.
  task automatic drain_block();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (CORES + 3) @(posedge clk_i);
  endtask

  task automatic write_fit_mode(logic [1:0] m);
    drain_block();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_mode(m);
  endtask

  // Result side: check every accepted result, then choose next cycle's stall.
  initial begin : result_sink
    int hold_left;
    int pick;

    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = LONG_HOLD;
      end else if (hold_left > 0) begin
        hold_left--;
      end else if (idle_enable) begin
        pick = $urandom_range(0, 99);
        if (pick < 60) hold_left = 0;
        else if (pick < 96) hold_left = $urandom_range(1, 3);
        else hold_left = $urandom_range(12, 40);
      end
      out_stall_i <= (hold_left > 0);
    end
  end

  // Count cycles with no handshake on either channel; bail out on a hang.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [1:0]        phase_mode;
    logic [1:0]        mode_order [4];
    logic [UTIL_W-1:0] util;
    logic              first;
    int                set_left;

    sb         = new();
    mode_order = '{FIT_FIRST, FIT_BEST, FIT_WORST, FIT_MODE_THREE};
    set_left   = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // First-fit: fill whole cores, exact boundary, oversized tasks.
    write_fit_mode(FIT_FIRST);
    send_request(17'd65536, 1'b1);
    send_request(17'd65536, 1'b0);
    send_request(17'd65535, 1'b0);
    send_request(17'd1, 1'b0);
    send_request(17'd32768, 1'b0);
    send_request(17'd1, 1'b0);
    send_request(17'd131071, 1'b0);
    send_request(17'd65537, 1'b1);

    // Best-fit: a zero task on empty cores is rejected, on a loaded core it fits.
    write_fit_mode(FIT_BEST);
    send_request(17'd0, 1'b1);
    send_request(17'd32768, 1'b0);
    send_request(17'd16384, 1'b0);
    send_request(17'd0, 1'b0);
    send_request(17'd65536, 1'b0);

    // Worst-fit: a full task never fits since the total must stay below 1.0.
    write_fit_mode(FIT_WORST);
    send_request(17'd65536, 1'b1);
    send_request(17'd65535, 1'b0);
    send_request(17'd1, 1'b0);
    send_request(17'd0, 1'b0);
    send_request(17'd131071, 1'b0);

    // Mode three behaves as first-fit.
    write_fit_mode(FIT_MODE_THREE);
    send_request(17'd32768, 1'b1);
    send_request(17'd32768, 1'b0);
    send_request(17'd32768, 1'b0);

    // Random phases: task sets of random length, with the odd stray set start.
    for (int phase = 0; phase < PHASES; phase++) begin
      phase_mode = (phase < 4) ? mode_order[phase] : 2'($urandom_range(0, 3));
      write_fit_mode(phase_mode);
      idle_enable = (phase % 3 != 2);
      for (int i = 0; i < PHASE_REQUESTS; i++) begin
        if (phase == 1 && i == 20) long_hold_req = 1'b1;
        first = 1'b0;
        if (set_left == 0) begin
          first    = 1'b1;
          set_left = $urandom_range(1, 12);
        end else if ($urandom_range(0, 99) < 5) begin
          first = 1'b1;
        end
        set_left--;
        util = ($urandom_range(0, 99) < 3) ? UTIL_W'($urandom) : pick_utilization();
        send_request(util, first);
      end
    end

    idle_enable = 1'b0;
    drain_block();
    $display("Sent %0d tasks over first, best, worst and mode-three phases:",
             sb.requests);
    $display("  %0d placed, %0d not schedulable, incl. a %0d-cycle output hold-off",
             sb.placed_seen, sb.rejected_seen, LONG_HOLD);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
